@@ src/srec_pkg.sv @@
// Shared types, character codes and helper functions of the S-record encoder.
`default_nettype none

package srec_pkg;

	// Input item kinds.
	localparam logic [1:0] KIND_HDR    = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_BYTE   = 2'd2;
	localparam logic [1:0] KIND_FINISH = 2'd3;

	// ASCII codes used in the record text.
	localparam logic [6:0] CH_S  = 7'h53;
	localparam logic [6:0] CH_0  = 7'h30;
	localparam logic [6:0] CH_1  = 7'h31;
	localparam logic [6:0] CH_5  = 7'h35;
	localparam logic [6:0] CH_9  = 7'h39;
	localparam logic [6:0] CH_CR = 7'h0D;
	localparam logic [6:0] CH_LF = 7'h0A;

	// Character positions within one record line.
	localparam logic [3:0] POS_S      = 4'd0;
	localparam logic [3:0] POS_TYPE   = 4'd1;
	localparam logic [3:0] POS_CNT_HI = 4'd2;
	localparam logic [3:0] POS_CNT_LO = 4'd3;
	localparam logic [3:0] POS_VAL_3  = 4'd4;
	localparam logic [3:0] POS_VAL_2  = 4'd5;
	localparam logic [3:0] POS_VAL_1  = 4'd6;
	localparam logic [3:0] POS_VAL_0  = 4'd7;
	localparam logic [3:0] POS_SUM_HI = 4'd8;
	localparam logic [3:0] POS_SUM_LO = 4'd9;
	localparam logic [3:0] POS_CR     = 4'd10;
	localparam logic [3:0] POS_LF     = 4'd11;

	localparam logic [7:0] SHORT_COUNT = 8'd3;

	// One command for the character sequencer.
	typedef struct packed {
		logic [6:0]  type_char;  // record type digit
		logic        byte_only;  // payload byte: starts at the low value digits
		logic [7:0]  count;
		logic [15:0] value;      // address, counter or payload byte
		logic [7:0]  csum;
		logic        tail;       // line ends with checksum and CR LF
		logic        two_part;   // finish: a second line follows with S9
		logic [15:0] value2;
		logic [7:0]  csum2;
	} srec_cmd_t;

	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		logic [6:0] ext;
		ext = {3'b000, nib};
		if (nib < 4'd10) begin
			hex_char = CH_0 + ext;
		end else begin
			hex_char = 7'h37 + ext;
		end
	endfunction

	function automatic logic [6:0] line_char(input srec_cmd_t cmd, input logic [3:0] pos,
			input logic second);
		logic [15:0] v;
		logic [7:0]  s;
		v = second ? cmd.value2 : cmd.value;
		s = second ? cmd.csum2 : cmd.csum;
		case (pos)
			POS_S:      line_char = CH_S;
			POS_TYPE:   line_char = second ? CH_9 : cmd.type_char;
			POS_CNT_HI: line_char = hex_char(cmd.count[7:4]);
			POS_CNT_LO: line_char = hex_char(cmd.count[3:0]);
			POS_VAL_3:  line_char = hex_char(v[15:12]);
			POS_VAL_2:  line_char = hex_char(v[11:8]);
			POS_VAL_1:  line_char = hex_char(v[7:4]);
			POS_VAL_0:  line_char = hex_char(v[3:0]);
			POS_SUM_HI: line_char = hex_char(s[7:4]);
			POS_SUM_LO: line_char = hex_char(s[3:0]);
			POS_CR:     line_char = CH_CR;
			POS_LF:     line_char = CH_LF;
			default:    line_char = CH_S;
		endcase
	endfunction

endpackage

`default_nettype wire

@@ src/srec_record_encoder.sv @@
// Top level of the S-record text encoder: front end, command queue, sequencer.
//
//   channel  direction  handshake          payload
//   input    in         push / full        kind, length, address, data_byte, start_address
//   result   out        empty / pop        char_out, last
//
// The sequencer gives one character a cycle from its output register unless pop
// is held low. An item gives 2 or 6 characters for a payload byte, 8 or 12 for
// a record start, 24 for a finish, none for a dropped byte.
// The front end takes an item every cycle until CMD_DEPTH commands wait in
// the queue. Reset clears the record state, the queue and the output valid flag.
// Holding pop low stalls the sequencer only; the front end keeps filling the queue.
`default_nettype none

module srec_record_encoder #(
	parameter int CMD_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  length,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  data_byte,
	input  wire logic [15:0] start_address,
	output logic             empty,
	input  wire logic        pop,
	output logic [6:0]       char_out,
	output logic             last
);

	srec_pkg::srec_cmd_t front_cmd;
	srec_pkg::srec_cmd_t head_cmd;
	logic                cmd_push;
	logic                cmd_pop;
	logic                cmd_empty;
	logic                take;

	assign take = push && !full;

	srec_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.kind          (kind),
		.length        (length),
		.address       (address),
		.data_byte     (data_byte),
		.start_address (start_address),
		.cmd           (front_cmd),
		.cmd_push      (cmd_push)
	);

	srec_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (front_cmd),
		.pop    (cmd_pop),
		.rdata  (head_cmd),
		.full   (full),
		.empty  (cmd_empty)
	);

	srec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head_cmd),
		.cmd_valid (!cmd_empty),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.char_out  (char_out),
		.last      (last)
	);

	// A command leaves the queue exactly when its final character is loaded.
	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> !empty && last)
		else $error("command retired without a final character");

	// The front end never writes into a full queue.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !full)
		else $error("command pushed into a full queue");

	// A full queue always has a head for the sequencer.
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !cmd_empty)
		else $error("queue full and empty at once");

endmodule

`default_nettype wire

@@ src/srec_front.sv @@
// Front end: tracks the open record and turns each accepted item into a command.
`default_nettype none

module srec_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               take,
	input  wire logic [1:0]         kind,
	input  wire logic [7:0]         length,
	input  wire logic [15:0]        address,
	input  wire logic [7:0]         data_byte,
	input  wire logic [15:0]        start_address,
	output srec_pkg::srec_cmd_t     cmd,
	output logic                    cmd_push
);

	logic        open_q;
	logic [7:0]  left_q;
	logic [7:0]  sum_q;
	logic [15:0] counter_q;

	logic        open_d;
	logic [7:0]  left_d;
	logic [7:0]  sum_d;
	logic [15:0] counter_d;

	logic [7:0]  count;
	logic [15:0] addr;
	logic [7:0]  head_sum;
	logic [7:0]  byte_sum;
	logic [7:0]  left_dec;
	logic [7:0]  s5_sum;
	logic [7:0]  s9_sum;

	always_comb begin
		count    = length + srec_pkg::SHORT_COUNT;
		addr     = (kind == srec_pkg::KIND_HDR) ? 16'h0000 : address;
		head_sum = count + addr[15:8] + addr[7:0];
		byte_sum = sum_q + data_byte;
		left_dec = left_q - 8'd1;
		s5_sum   = srec_pkg::SHORT_COUNT + counter_q[15:8] + counter_q[7:0];
		s9_sum   = srec_pkg::SHORT_COUNT + start_address[15:8] + start_address[7:0];

		open_d    = open_q;
		left_d    = left_q;
		sum_d     = sum_q;
		counter_d = counter_q;
		cmd_push  = 1'b0;

		cmd           = '0;
		cmd.count     = count;
		cmd.value     = addr;
		cmd.csum      = ~head_sum;
		cmd.value2    = start_address;
		cmd.csum2     = ~s9_sum;
		cmd.type_char = srec_pkg::CH_0;

		case (kind)
			srec_pkg::KIND_HDR, srec_pkg::KIND_DATA: begin
				cmd.type_char = (kind == srec_pkg::KIND_HDR) ? srec_pkg::CH_0 : srec_pkg::CH_1;
				cmd.tail      = (length == 8'd0);
				cmd_push      = take;
				if (take) begin
					open_d    = (length != 8'd0);
					left_d    = length;
					sum_d     = head_sum;
					counter_d = (kind == srec_pkg::KIND_HDR) ? 16'h0000 : counter_q + 16'd1;
				end
			end
			srec_pkg::KIND_BYTE: begin
				cmd.byte_only = 1'b1;
				cmd.value     = {8'h00, data_byte};
				cmd.csum      = ~byte_sum;
				cmd.tail      = (left_dec == 8'd0);
				// A byte with no open record is dropped.
				cmd_push      = take && open_q;
				if (take && open_q) begin
					sum_d  = byte_sum;
					left_d = left_dec;
					open_d = (left_dec != 8'd0);
				end
			end
			default: begin
				cmd.type_char = srec_pkg::CH_5;
				cmd.count     = srec_pkg::SHORT_COUNT;
				cmd.value     = counter_q;
				cmd.csum      = ~s5_sum;
				cmd.tail      = 1'b1;
				cmd.two_part  = 1'b1;
				cmd_push      = take;
				if (take) begin
					open_d = 1'b0;
					left_d = 8'd0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= 1'b0;
			left_q    <= 8'd0;
			sum_q     <= 8'd0;
			counter_q <= 16'd0;
		end else begin
			open_q    <= open_d;
			left_q    <= left_d;
			sum_q     <= sum_d;
			counter_q <= counter_d;
		end
	end

endmodule

`default_nettype wire

@@ src/srec_cmd_fifo.sv @@
// Command queue between the front end and the character sequencer.
`default_nettype none

module srec_cmd_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire srec_pkg::srec_cmd_t wdata,
	input  wire logic                pop,
	output srec_pkg::srec_cmd_t      rdata,
	output logic                     full,
	output logic                     empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	srec_pkg::srec_cmd_t entries_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ src/srec_back.sv @@
// Back end: walks each command one character a cycle into the output register, unless pop stalls it.
`default_nettype none

module srec_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire srec_pkg::srec_cmd_t cmd,
	input  wire logic                cmd_valid,
	output logic                     cmd_pop,
	input  wire logic                pop,
	output logic                     empty,
	output logic [6:0]               char_out,
	output logic                     last
);

	logic       active_q;
	logic [3:0] pos_q;
	logic       half_q;
	logic       valid_q;
	logic [6:0] char_q;
	logic       last_q;

	logic       advance;
	logic [3:0] cur_pos;
	logic       cur_half;
	logic       line_end;
	logic       is_last;

	always_comb begin
		advance  = cmd_valid && (!valid_q || pop);
		cur_pos  = active_q ? pos_q : (cmd.byte_only ? srec_pkg::POS_VAL_1 : srec_pkg::POS_S);
		cur_half = active_q && half_q;
		line_end = (cur_pos == (cmd.tail ? srec_pkg::POS_LF : srec_pkg::POS_VAL_0));
		is_last  = line_end && (!cmd.two_part || cur_half);
		cmd_pop  = advance && is_last;
	end

	assign empty    = !valid_q;
	assign char_out = char_q;
	assign last     = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= 4'd0;
			half_q   <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				valid_q <= 1'b1;
				if (is_last) begin
					active_q <= 1'b0;
				end else if (line_end) begin
					// The S5 line is done; the S9 line follows.
					active_q <= 1'b1;
					pos_q    <= srec_pkg::POS_S;
					half_q   <= 1'b1;
				end else begin
					active_q <= 1'b1;
					pos_q    <= cur_pos + 4'd1;
					half_q   <= cur_half;
				end
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			char_q <= srec_pkg::line_char(cmd, cur_pos, cur_half);
			last_q <= is_last;
		end
	end

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench of the S-record encoder: directed rows and random streams.
`timescale 1ns / 100ps

module tb_top;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  length;
		logic [15:0] address;
		logic [7:0]  data_byte;
		logic [15:0] start_address;
	} srec_item_t;

	typedef struct packed {
		logic [6:0] ch;
		logic       fin;
	} srec_char_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  kind;
	logic [7:0]  length;
	logic [15:0] address;
	logic [7:0]  data_byte;
	logic [15:0] start_address;
	logic        empty;
	logic        pop;
	logic [6:0]  char_out;
	logic        last;

	srec_record_encoder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.kind(kind),
		.length(length),
		.address(address),
		.data_byte(data_byte),
		.start_address(start_address),
		.empty(empty),
		.pop(pop),
		.char_out(char_out),
		.last(last)
	);

	// Encoder state as the text predictor sees it.
	logic        rec_open;
	logic [7:0]  bytes_left;
	logic [7:0]  line_sum;
	logic [15:0] s1_count;

	logic [6:0]  burst[$];
	srec_char_t  text_due[$];

	srec_item_t  dir_items[$];
	string       dir_text[$];
	bit          dir_typed[$];

	int mismatches = 0;
	int fed_items = 0;
	int send_idle = 0;
	int recv_stall = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
		return (nib < 4'd10) ? srec_pkg::CH_0 + {3'b000, nib} : 7'h37 + {3'b000, nib};
	endfunction

	function automatic void add_char(input logic [6:0] c);
		burst.insert(burst.size(), c);
	endfunction

	function automatic void put_hex8(input logic [7:0] v);
		add_char(hex_ascii(v[7:4]));
		add_char(hex_ascii(v[3:0]));
	endfunction

	function automatic void put_line_end(input logic [7:0] sum);
		put_hex8(~sum);
		add_char(srec_pkg::CH_CR);
		add_char(srec_pkg::CH_LF);
	endfunction

	function automatic void put_short_line(input logic [6:0] type_ch, input logic [15:0] value);
		add_char(srec_pkg::CH_S);
		add_char(type_ch);
		put_hex8(8'd3);
		put_hex8(value[15:8]);
		put_hex8(value[7:0]);
		put_line_end(8'd3 + value[15:8] + value[7:0]);
	endfunction

	// Computes the characters one item causes and advances the record state.
	function automatic void encode_item(input srec_item_t it);
		logic [7:0]  count;
		logic [15:0] addr;
		burst.delete();
		case (it.kind)
			srec_pkg::KIND_HDR, srec_pkg::KIND_DATA: begin
				count = it.length + 8'd3;
				addr = (it.kind == srec_pkg::KIND_HDR) ? 16'h0000 : it.address;
				s1_count = (it.kind == srec_pkg::KIND_HDR) ? 16'h0000 : s1_count + 16'd1;
				add_char(srec_pkg::CH_S);
				add_char((it.kind == srec_pkg::KIND_HDR) ? srec_pkg::CH_0 : srec_pkg::CH_1);
				put_hex8(count);
				put_hex8(addr[15:8]);
				put_hex8(addr[7:0]);
				line_sum = count + addr[15:8] + addr[7:0];
				bytes_left = it.length;
				rec_open = (it.length != 8'd0);
				if (!rec_open) begin
					put_line_end(line_sum);
				end
			end
			srec_pkg::KIND_BYTE: begin
				if (rec_open) begin
					put_hex8(it.data_byte);
					line_sum = line_sum + it.data_byte;
					bytes_left = bytes_left - 8'd1;
					if (bytes_left == 8'd0) begin
						put_line_end(line_sum);
						rec_open = 1'b0;
					end
				end
			end
			default: begin
				rec_open = 1'b0;
				bytes_left = 8'd0;
				put_short_line(srec_pkg::CH_5, s1_count);
				put_short_line(srec_pkg::CH_9, it.start_address);
			end
		endcase
	endfunction

	function automatic srec_item_t rand_item();
		srec_item_t it;
		it.kind = 2'($urandom_range(3));
		it.length = 8'($urandom_range(255));
		it.address = 16'($urandom_range(65535));
		it.data_byte = 8'($urandom_range(255));
		it.start_address = 16'($urandom_range(65535));
		return it;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= 40) begin
			$display("MISMATCH %s at %0t ns: got %h, expected %h", what, $time, got, want);
		end
	endtask

	task automatic add_row(input logic [1:0] k, input logic [7:0] len, input logic [15:0] addr,
			input logic [7:0] b, input logic [15:0] start, input bit typed, input string text);
		srec_item_t it;
		it.kind = k;
		it.length = len;
		it.address = addr;
		it.data_byte = b;
		it.start_address = start;
		dir_items.insert(dir_items.size(), it);
		dir_typed.insert(dir_typed.size(), typed);
		dir_text.insert(dir_text.size(), text);
	endtask

	// Offers one item, waits for it to be taken and queues the characters it should cause.
	task automatic send_item(input srec_item_t it, input bit typed, input string text);
		int         i;
		byte        c;
		srec_char_t due;
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		kind <= it.kind;
		length <= it.length;
		address <= it.address;
		data_byte <= it.data_byte;
		start_address <= it.start_address;
		do @(posedge clk); while (full);
		fed_items++;
		encode_item(it);
		if (typed) begin
			burst.delete();
			for (i = 0; i < text.len(); i++) begin
				c = text[i];
				// A blank in the typed text stands for the CR LF that ends a line.
				if (c == " ") begin
					add_char(srec_pkg::CH_CR);
					add_char(srec_pkg::CH_LF);
				end else begin
					add_char(c[6:0]);
				end
			end
		end
		for (i = 0; i < burst.size(); i++) begin
			due.ch = burst[i];
			due.fin = (i == burst.size() - 1);
			text_due.insert(text_due.size(), due);
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		while (text_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic random_phase(input int idle_pct, input int stall_pct, input int goal);
		srec_item_t it;
		int len;
		int nb;
		int pick;
		int stop_at;
		send_idle = idle_pct;
		recv_stall = stall_pct;
		stop_at = fed_items + goal;
		while (fed_items < stop_at) begin
			pick = $urandom_range(99);
			it = rand_item();
			if (pick < 75) begin
				it.kind = ($urandom_range(5) == 0) ? srec_pkg::KIND_HDR : srec_pkg::KIND_DATA;
				case ($urandom_range(9))
					0: len = $urandom_range(40);
					1: len = $urandom_range(255);
					default: len = $urandom_range(8);
				endcase
				it.length = 8'(len);
				nb = len;
				// Long records are cut short and left open, and a share of the others may be.
				if (len > 40 || pick >= 63) begin
					nb = $urandom_range(len < 12 ? len : 12);
				end
				send_item(it, 1'b0, "");
				repeat (nb) begin
					it = rand_item();
					it.kind = srec_pkg::KIND_BYTE;
					send_item(it, 1'b0, "");
				end
			end else begin
				it.kind = (pick >= 88) ? srec_pkg::KIND_FINISH : srec_pkg::KIND_BYTE;
				send_item(it, 1'b0, "");
			end
		end
		drain();
	endtask

	task automatic check_char();
		srec_char_t want;
		if (text_due.size() == 0) begin
			report_mismatch("unexpected character", 32'(char_out), 32'd0);
		end else begin
			want = text_due.pop_front();
			if (char_out !== want.ch) begin
				report_mismatch("char_out", 32'(char_out), 32'(want.ch));
			end
			if (last !== want.fin) begin
				report_mismatch("last", 32'(last), 32'(want.fin));
			end
		end
	endtask

	initial begin
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				check_char();
			end
			pop <= ($urandom_range(99) >= recv_stall);
		end
	end

	initial begin
		int i;
		arst_n <= 1'b0;
		push <= 1'b0;
		kind <= srec_pkg::KIND_HDR;
		length <= 8'd0;
		address <= 16'd0;
		data_byte <= 8'd0;
		start_address <= 16'd0;
		rec_open = 1'b0;
		bytes_left = 8'd0;
		line_sum = 8'd0;
		s1_count = 16'd0;

		add_row(srec_pkg::KIND_FINISH, 8'd0,   16'h0000, 8'h00, 16'h0000, 1'b1,
			"S5030000FC S9030000FC ");
		add_row(srec_pkg::KIND_BYTE,   8'd0,   16'h0000, 8'hFF, 16'h0000, 1'b1, "");
		add_row(srec_pkg::KIND_HDR,    8'd0,   16'hFFFF, 8'h00, 16'h0000, 1'b1, "S0030000FC ");
		add_row(srec_pkg::KIND_DATA,   8'd0,   16'hFFFF, 8'h00, 16'hFFFF, 1'b1, "S103FFFFFE ");
		add_row(srec_pkg::KIND_DATA,   8'd0,   16'h0000, 8'hFF, 16'h0000, 1'b1, "S1030000FC ");
		add_row(srec_pkg::KIND_HDR,    8'd2,   16'h1234, 8'h00, 16'h0000, 1'b0, "");
		add_row(srec_pkg::KIND_BYTE,   8'd0,   16'h0000, 8'h48, 16'h0000, 1'b0, "");
		add_row(srec_pkg::KIND_BYTE,   8'd0,   16'h0000, 8'h69, 16'h0000, 1'b0, "");
		add_row(srec_pkg::KIND_BYTE,   8'd255, 16'hFFFF, 8'h00, 16'hFFFF, 1'b1, "");
		add_row(srec_pkg::KIND_DATA,   8'd3,   16'h8001, 8'h00, 16'h0000, 1'b0, "");
		add_row(srec_pkg::KIND_BYTE,   8'd0,   16'h0000, 8'h00, 16'h0000, 1'b0, "");
		add_row(srec_pkg::KIND_BYTE,   8'd0,   16'h0000, 8'hFF, 16'h0000, 1'b0, "");
		add_row(srec_pkg::KIND_BYTE,   8'd0,   16'h0000, 8'h80, 16'h0000, 1'b0, "");
		// A new start abandons the record opened below without a checksum line end.
		add_row(srec_pkg::KIND_DATA,   8'd252, 16'h7FFE, 8'h00, 16'h0000, 1'b0, "");
		add_row(srec_pkg::KIND_BYTE,   8'd0,   16'h0000, 8'hA5, 16'h0000, 1'b0, "");
		add_row(srec_pkg::KIND_DATA,   8'd1,   16'hC0DE, 8'h00, 16'h0000, 1'b0, "");
		add_row(srec_pkg::KIND_BYTE,   8'd0,   16'h0000, 8'h5A, 16'h0000, 1'b0, "");
		// Lengths near the top make the byte count wrap past 255.
		add_row(srec_pkg::KIND_DATA,   8'd255, 16'h00FF, 8'h00, 16'h0000, 1'b0, "");
		add_row(srec_pkg::KIND_BYTE,   8'd0,   16'h0000, 8'h01, 16'h0000, 1'b0, "");
		add_row(srec_pkg::KIND_FINISH, 8'd0,   16'h0000, 8'h00, 16'h8000, 1'b0, "");
		add_row(srec_pkg::KIND_BYTE,   8'd0,   16'h0000, 8'h77, 16'h0000, 1'b1, "");
		add_row(srec_pkg::KIND_DATA,   8'd253, 16'hFFFF, 8'h00, 16'h0000, 1'b0, "");
		add_row(srec_pkg::KIND_HDR,    8'd254, 16'h0000, 8'h00, 16'h0000, 1'b0, "");
		add_row(srec_pkg::KIND_FINISH, 8'd0,   16'h0000, 8'h00, 16'hFFFF, 1'b0, "");

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < dir_items.size(); i++) begin
			send_item(dir_items[i], dir_typed[i], dir_text[i]);
		end
		drain();

		random_phase(0, 0, 60);
		random_phase(74, 0, 60);
		random_phase(0, 74, 60);
		random_phase(27, 27, 60);

		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#200_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ filelist.f @@
src/srec_pkg.sv
src/srec_front.sv
src/srec_cmd_fifo.sv
src/srec_back.sv
src/srec_record_encoder.sv
dv/tb_top.sv
